// File: rtl/core/rwc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the rolling window checksum core.
// Depends on nothing; the cell modules and the top level import it.
package rwc_pkg;

    localparam int DATA_W     = 8;
    localparam int SUM_W      = 16;
    localparam int CFG_W      = 13;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SUM_W-1:0] BYTE_BIAS        = 16'd31;
    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 13'd1024;

    // Register index, taken from the word address bit of paddr.
    localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

    // Handed from the window cell to the drop cell.
    typedef struct packed {
        logic [DATA_W-1:0] old_byte;
        logic [DATA_W-1:0] new_byte;
        logic              roll;
        logic              restart;
        logic              full;
    } t_win_item;

    // Handed from the drop cell to the sum cell.
    typedef struct packed {
        logic [SUM_W-1:0] d_low;
        logic [SUM_W-1:0] d_high;
        logic             restart;
        logic             full;
    } t_sum_item;

endpackage

// File: rtl/core/rwc_in_if.sv
`timescale 1ns / 1ps
// Input channel of the rolling window checksum core: one signed byte and
// a restart flag per item. No dependencies.
interface rwc_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] data_byte;
    logic              restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// File: rtl/core/rwc_out_if.sv
`timescale 1ns / 1ps
// Output channel of the rolling window checksum core: packed checksum and
// window-full flag per item. No dependencies.
interface rwc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] checksum;
    logic        window_full;

    modport source (output valid, output checksum, output window_full, input ready);
    modport sink   (input valid, input checksum, input window_full, output ready);
endinterface

// File: rtl/core/rwc_window_cell.sv
`timescale 1ns / 1ps
// First cell: byte delay line memory, write slot and fill count.
// Depends on rwc_pkg.
module rwc_window_cell #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_clear,
    input  logic [$clog2(WINDOW_DEPTH + 1)-1:0]     i_len,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic [rwc_pkg::DATA_W-1:0]              i_byte,
    input  logic                                    i_restart,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output rwc_pkg::t_win_item                      o_item
);
    import rwc_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int LW = $clog2(WINDOW_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [WINDOW_DEPTH];

    logic              r_valid;
    logic [AW-1:0]     r_slot, n_slot, w_slot;
    logic [LW-1:0]     r_fill, n_fill, w_fill;
    logic              w_take, w_roll;
    logic [DATA_W-1:0] r_old, r_new;
    logic              r_roll, r_restart, r_full;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    always_comb begin
        w_fill = i_restart ? '0 : r_fill;
        w_slot = i_restart ? '0 : r_slot;
        w_roll = (w_fill == i_len);
        n_fill = w_roll ? w_fill : w_fill + LW'(1);
        if ((LW'(w_slot) + LW'(1)) == i_len) begin
            n_slot = '0;
        end else begin
            n_slot = w_slot + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
            r_fill  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (i_clear) begin
                r_slot <= '0;
                r_fill <= '0;
            end else if (w_take) begin
                r_slot <= n_slot;
                r_fill <= n_fill;
            end
        end
    end

    // Read before write: the slot being overwritten yields the oldest byte.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_old          <= r_mem[w_slot];
            r_mem[w_slot]  <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_new     <= i_byte;
            r_roll    <= w_roll;
            r_restart <= i_restart;
            r_full    <= (n_fill == i_len);
        end
    end

    assign o_valid          = r_valid;
    assign o_item.old_byte  = r_old;
    assign o_item.new_byte  = r_new;
    assign o_item.roll      = r_roll;
    assign o_item.restart   = r_restart;
    assign o_item.full      = r_full;

endmodule

// File: rtl/core/rwc_drop_cell.sv
`timescale 1ns / 1ps
// Second cell: forms the low-sum step and the high-sum correction
// -len * (oldest + 31). Depends on rwc_pkg.
module rwc_drop_cell #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(WINDOW_DEPTH + 1)-1:0] i_len,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  rwc_pkg::t_win_item                  i_item,
    output logic                                o_valid,
    input  logic                                i_ready,
    output rwc_pkg::t_sum_item                  o_item
);
    import rwc_pkg::*;

    logic             r_valid;
    logic             w_take;
    logic [SUM_W-1:0] w_len16, w_old16, w_new16, w_old_off, w_drop;
    t_sum_item        r_item, n_item;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // The length only matters modulo 2^16, as the sums wrap there.
    assign w_len16   = SUM_W'(i_len);
    assign w_old16   = {{(SUM_W - DATA_W){i_item.old_byte[DATA_W-1]}}, i_item.old_byte};
    assign w_new16   = {{(SUM_W - DATA_W){i_item.new_byte[DATA_W-1]}}, i_item.new_byte};
    assign w_old_off = w_old16 + BYTE_BIAS;
    assign w_drop    = w_len16 * w_old_off;

    always_comb begin
        n_item.restart = i_item.restart;
        n_item.full    = i_item.full;
        if (i_item.roll) begin
            n_item.d_low  = w_new16 - w_old16;
            n_item.d_high = '0 - w_drop;
        end else begin
            n_item.d_low  = w_new16 + BYTE_BIAS;
            n_item.d_high = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/rwc_sum_cell.sv
`timescale 1ns / 1ps
// Last cell: holds the low and high sums and the output register.
// Depends on rwc_pkg.
module rwc_sum_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rwc_pkg::t_sum_item         i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [2*rwc_pkg::SUM_W-1:0] o_checksum,
    output logic                       o_full
);
    import rwc_pkg::*;

    logic               r_valid;
    logic               w_take;
    logic [SUM_W-1:0]   r_low, r_high, w_low, w_high;
    logic [2*SUM_W-1:0] r_checksum;
    logic               r_full;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    assign w_low  = (i_item.restart ? '0 : r_low) + i_item.d_low;
    assign w_high = (i_item.restart ? '0 : r_high) + w_low + i_item.d_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_low   <= '0;
            r_high  <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (i_clear) begin
                r_low  <= '0;
                r_high <= '0;
            end else if (w_take) begin
                r_low  <= w_low;
                r_high <= w_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_checksum <= {w_high, w_low};
            r_full     <= i_item.full;
        end
    end

    assign o_valid    = r_valid;
    assign o_checksum = r_checksum;
    assign o_full     = r_full;

endmodule

// File: rtl/core/rolling_window_checksum_core.sv
`timescale 1ns / 1ps
// Top level of the rolling window checksum core: APB register, three cells.
// Depends on rwc_pkg, rwc_in_if, rwc_out_if and the rwc_*_cell modules.
//
//  channel   | direction | handshake      | payload
//  ----------+-----------+----------------+------------------------------------
//  i_in_ch   | in        | valid / ready  | data_byte (s8), restart
//  o_out_ch  | out       | valid / ready  | checksum (high:low), window_full
//  APB       | in        | psel / penable | window_len at address 0
//
// One item per cycle while the output is not stalled; a result is shown once
// its item has passed the window, drop and sum cell registers. The sum cell
// sets the rate with a combinational sum update. Each cell stalls only if it is
// full and its neighbour is not taking, so up to three items are in flight.
// Reset clears sums, fill count, write slot and sets window_len to 1024; the
// delay line memory is not cleared and needs no clearing pass.
module rolling_window_checksum_core #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    rwc_in_if.sink                             i_in_ch,
    rwc_out_if.source                          o_out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rwc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rwc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rwc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import rwc_pkg::*;

    localparam int LW        = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_RESET = (int'(WINDOW_LEN_RESET) > WINDOW_DEPTH) ?
                               WINDOW_DEPTH : int'(WINDOW_LEN_RESET);

    logic             w_cfg_wr;
    logic [CFG_W-1:0] r_window_len;
    logic [LW-1:0]    r_len, n_len;

    logic             w_win_valid, w_win_ready;
    t_win_item        w_win_item;
    logic             w_drop_valid, w_drop_ready;
    t_sum_item        w_drop_item;

    // Register interface.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2:2] == REG_WINDOW_LEN);
    assign prdata   = (paddr[2:2] == REG_WINDOW_LEN) ?
                      APB_DATA_W'(r_window_len) : '0;

    // Effective length: zero counts as one, oversize saturates at the depth.
    always_comb begin
        if (pwdata[CFG_W-1:0] == '0) begin
            n_len = LW'(1);
        end else if (32'(pwdata[CFG_W-1:0]) > 32'(WINDOW_DEPTH)) begin
            n_len = LW'(WINDOW_DEPTH);
        end else begin
            n_len = LW'(pwdata[CFG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
            r_len        <= LW'(LEN_RESET);
        end else if (w_cfg_wr) begin
            r_window_len <= pwdata[CFG_W-1:0];
            r_len        <= n_len;
        end
    end

    rwc_window_cell #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_cfg_wr),
        .i_len     (r_len),
        .i_valid   (i_in_ch.valid),
        .o_ready   (i_in_ch.ready),
        .i_byte    (i_in_ch.data_byte),
        .i_restart (i_in_ch.restart),
        .o_valid   (w_win_valid),
        .i_ready   (w_win_ready),
        .o_item    (w_win_item)
    );

    rwc_drop_cell #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_drop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_len   (r_len),
        .i_valid (w_win_valid),
        .o_ready (w_win_ready),
        .i_item  (w_win_item),
        .o_valid (w_drop_valid),
        .i_ready (w_drop_ready),
        .o_item  (w_drop_item)
    );

    rwc_sum_cell u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (w_cfg_wr),
        .i_valid    (w_drop_valid),
        .o_ready    (w_drop_ready),
        .i_item     (w_drop_item),
        .o_valid    (o_out_ch.valid),
        .i_ready    (o_out_ch.ready),
        .o_checksum (o_out_ch.checksum),
        .o_full     (o_out_ch.window_full)
    );

endmodule

// File: rtl/core/rwc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the rolling window checksum core, with its bind.
// Depends on rolling_window_checksum_core.
module rwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_checksum,
    input logic        i_window_full
);
    // Items accepted but not yet delivered; three cells hold at most three.
    logic [2:0] r_pending;
    logic       w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_pending <= r_pending + 3'd1;
        end else if (!w_in_acc && w_out_acc) begin
            r_pending <= r_pending - 3'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result shown straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_checksum) && $stable(i_window_full))
        else $error("stalled result changed or vanished");

    a_free_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled although output register is empty");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 3'd0)
        else $error("result shown with no item in flight");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("more items in flight than cells");

endmodule

bind rolling_window_checksum_core rwc_checker u_rwc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_ch.valid),
    .i_in_ready    (i_in_ch.ready),
    .i_out_valid   (o_out_ch.valid),
    .i_out_ready   (o_out_ch.ready),
    .i_checksum    (o_out_ch.checksum),
    .i_window_full (o_out_ch.window_full)
);
